// ===== rtl/core/servo_status_packet_checker_top_assert.svh =====
// assertion macros shared by the status packet checker modules
`ifndef SERVO_STATUS_PACKET_CHECKER_TOP_ASSERT_SVH
`define SERVO_STATUS_PACKET_CHECKER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SSPC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sspc assertion failed");

// antecedent implies consequent in the next cycle
`define SSPC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sspc assertion failed");

`endif

// ===== rtl/core/sspc_pkg.sv =====
// types and constants of the status packet checker
`timescale 1ns / 1ps

package sspc_pkg;

   localparam logic [7:0] HEADER_BYTE    = 8'hFF;
   localparam int         MIN_PACKET_LEN = 6;

   typedef enum logic [1:0] {
      VERDICT_OK       = 2'd0,
      VERDICT_CORRUPT  = 2'd1,
      VERDICT_MISMATCH = 2'd2
   } verdict_type;

   typedef struct packed {
      verdict_type verdict;
      logic [7:0]  status_id;
      logic [7:0]  error_bits;
      logic        error_present;
      logic [15:0] param_word;
   } result_type;

endpackage

// ===== rtl/core/servo_status_packet_checker_top.sv =====
// top level of the servo status packet checker
`timescale 1ns / 1ps

// Checks a received servo bus status packet that arrives one byte per req
// transfer, with req_last_byte on the final byte. The expected id and read
// count are sampled with the first byte of each packet. One rsp transfer
// follows each packet: verdict ok, corrupt (shorter than 6 bytes, a bad 0xff
// header, or a checksum byte missing or wrong) or mismatch (wrong id, or a
// size other than 6 plus the read count), together with the id, the error
// byte, an error flag and the first two parameter bytes as a word. Bytes
// enter at one per cycle while req is not stalled; the parser updates its
// running sum and captures fields as each byte is accepted. Verdicts pass
// through a QUEUE_DEPTH entry queue and an output register; req stalls while
// the queue is full, only possible once rsp stalls with the register full.
// Verdicts are queued with their last byte. MAX_PACKET_BYTES bounds the byte
// counter; longer packets count as MAX_PACKET_BYTES + 1 bytes.

module servo_status_packet_checker_top #(
   parameter int MAX_PACKET_BYTES = 511,
   parameter int QUEUE_DEPTH      = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_last_byte,
   input  logic [7:0]  req_expected_id,
   input  logic [7:0]  req_expected_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_verdict,
   output logic [7:0]  rsp_status_id,
   output logic [7:0]  rsp_error_bits,
   output logic        rsp_error_present,
   output logic [15:0] rsp_param_word
);
   import sspc_pkg::*;

   // front to queue
   logic       push;
   result_type push_data;
   logic       queue_full;

   // queue to output stage
   logic       q_pop;
   logic       q_not_empty;
   result_type q_data;

   // parser: one byte per transfer, verdict built on the last byte
   sspc_front #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .req_last_byte      (req_last_byte),
      .req_expected_id    (req_expected_id),
      .req_expected_count (req_expected_count),
      .queue_full         (queue_full),
      .push               (push),
      .push_data          (push_data)
   );

   // decouples parser from a stalled consumer
   sspc_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   // registered result toward rsp
   sspc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_not_empty       (q_not_empty),
      .q_data            (q_data),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_verdict       (rsp_verdict),
      .rsp_status_id     (rsp_status_id),
      .rsp_error_bits    (rsp_error_bits),
      .rsp_error_present (rsp_error_present),
      .rsp_param_word    (rsp_param_word)
   );

endmodule

// ===== rtl/core/sspc_front.sv =====
// front end: byte parsing, header and checksum tracking, verdict per packet
`timescale 1ns / 1ps

module sspc_front #(
   parameter int MAX_PACKET_BYTES = 511
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_rx_byte,
   input  logic                req_last_byte,
   input  logic [7:0]          req_expected_id,
   input  logic [7:0]          req_expected_count,
   input  logic                queue_full,
   output logic                push,
   output sspc_pkg::result_type push_data
);
   import sspc_pkg::*;

   localparam int CNT_W  = $clog2(MAX_PACKET_BYTES + 1);
   localparam int SIZE_W = $clog2(MAX_PACKET_BYTES + 2);
   localparam int CMP_W  = (SIZE_W > 10) ? SIZE_W : 10;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             header_ff, header_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       length_ff, length_in;
   logic [7:0]       id_ff, id_in;
   logic [7:0]       error_ff, error_in;
   logic [7:0]       plow_ff, plow_in;
   logic [7:0]       phigh_ff, phigh_in;
   logic             matched_ff, matched_in;
   logic             checked_ff, checked_in;
   logic [7:0]       want_id_ff, want_id_in;
   logic [7:0]       want_cnt_ff, want_cnt_in;

   logic             accept;
   logic             is_sum;
   logic [CMP_W-1:0] k_wide;
   logic [CMP_W-1:0] size_wide;
   verdict_type      verdict;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && req_last_byte;
   assign k_wide    = CMP_W'(count_ff);
   assign size_wide = k_wide + CMP_W'(1);

   always_comb begin
      want_id_in  = (count_ff == '0) ? req_expected_id : want_id_ff;
      want_cnt_in = (count_ff == '0) ? req_expected_count : want_cnt_ff;
      header_in   = header_ff;
      if ((k_wide <= CMP_W'(1)) && (req_rx_byte != HEADER_BYTE)) begin
         header_in = 1'b0;
      end
      id_in     = (k_wide == CMP_W'(2)) ? req_rx_byte : id_ff;
      length_in = (k_wide == CMP_W'(3)) ? req_rx_byte : length_ff;
      error_in  = (k_wide == CMP_W'(4)) ? req_rx_byte : error_ff;
      plow_in   = (k_wide == CMP_W'(5)) ? req_rx_byte : plow_ff;
      phigh_in  = (k_wide == CMP_W'(6)) ? req_rx_byte : phigh_ff;

      // zero length: the length byte itself is the checksum
      if (k_wide == CMP_W'(3)) begin
         is_sum = (req_rx_byte == 8'd0);
      end else begin
         is_sum = (k_wide >= CMP_W'(4)) && (k_wide == CMP_W'(length_ff) + CMP_W'(3));
      end

      sum_in     = sum_ff;
      checked_in = checked_ff;
      matched_in = matched_ff;
      if (!checked_ff && (k_wide >= CMP_W'(2))) begin
         if (is_sum) begin
            checked_in = 1'b1;
            matched_in = (req_rx_byte == ~sum_ff);
         end else begin
            sum_in = sum_ff + req_rx_byte;
         end
      end

      if (count_ff < CNT_W'(MAX_PACKET_BYTES)) begin
         count_in = count_ff + CNT_W'(1);
      end else begin
         count_in = count_ff;
      end

      if ((size_wide < CMP_W'(MIN_PACKET_LEN)) || !header_in || !checked_in || !matched_in)
      begin
         verdict = VERDICT_CORRUPT;
      end else if ((id_in != want_id_in) ||
                   (size_wide != CMP_W'(MIN_PACKET_LEN) + CMP_W'(want_cnt_in))) begin
         verdict = VERDICT_MISMATCH;
      end else begin
         verdict = VERDICT_OK;
      end

      push_data.verdict       = verdict;
      push_data.status_id     = id_in;
      push_data.error_bits    = error_in;
      push_data.error_present = (error_in != 8'd0);
      push_data.param_word    = {phigh_in, plow_in};
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         count_ff    <= '0;
         header_ff   <= 1'b1;
         sum_ff      <= '0;
         length_ff   <= '0;
         id_ff       <= '0;
         error_ff    <= '0;
         plow_ff     <= '0;
         phigh_ff    <= '0;
         matched_ff  <= 1'b0;
         checked_ff  <= 1'b0;
         want_id_ff  <= '0;
         want_cnt_ff <= '0;
      end else if (accept) begin
         count_ff    <= count_in;
         header_ff   <= header_in;
         sum_ff      <= sum_in;
         length_ff   <= length_in;
         id_ff       <= id_in;
         error_ff    <= error_in;
         plow_ff     <= plow_in;
         phigh_ff    <= phigh_in;
         matched_ff  <= matched_in;
         checked_ff  <= checked_in;
         want_id_ff  <= want_id_in;
         want_cnt_ff <= want_cnt_in;
      end
   end

`include "servo_status_packet_checker_top_assert.svh"

   `SSPC_ASSERT_NEXT(a_front_clear_after_last, clock, reset, push, count_ff == '0 && header_ff)

endmodule

// ===== rtl/core/sspc_queue.sv =====
// short result queue between front end and output stage
`timescale 1ns / 1ps

module sspc_queue #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sspc_pkg::result_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output sspc_pkg::result_type pop_data
);
   import sspc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   result_type       entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

`include "servo_status_packet_checker_top_assert.svh"

   `SSPC_ASSERT_NOW(a_queue_no_overflow, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `SSPC_ASSERT_NEXT(a_queue_push_grows, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

// ===== rtl/core/sspc_back.sv =====
// output stage: result register toward the consumer
`timescale 1ns / 1ps

module sspc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_not_empty,
   input  sspc_pkg::result_type q_data,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_verdict,
   output logic [7:0]           rsp_status_id,
   output logic [7:0]           rsp_error_bits,
   output logic                 rsp_error_present,
   output logic [15:0]          rsp_param_word
);
   import sspc_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   assign q_pop = q_not_empty && (!valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff <= q_data;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_verdict       = data_ff.verdict;
   assign rsp_status_id     = data_ff.status_id;
   assign rsp_error_bits    = data_ff.error_bits;
   assign rsp_error_present = data_ff.error_present;
   assign rsp_param_word    = data_ff.param_word;

`include "servo_status_packet_checker_top_assert.svh"

   `SSPC_ASSERT_NEXT(a_back_pop_shows, clock, reset, q_pop, valid_ff && data_ff == $past(q_data))

endmodule
